/* design/pfba_pkg.sv */
// Shared types and constants of the page frame bitmap allocator.
package pfba_pkg;

  localparam int CMD_W      = 2;
  localparam int PAGE_W     = 12;
  localparam int STATUS_W   = 2;
  localparam int COUNT_W    = 13;
  localparam int POS_W      = 6;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 16;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 2;

  localparam logic [COUNT_W-1:0]    COUNT_RESET    = 13'd4096;
  localparam logic [CFG_ADDR_W-1:0] REG_PAGE_COUNT = 2'd0;

  typedef enum logic [CMD_W-1:0] {
    CMD_MARK_USED = 2'd0,
    CMD_MARK_FREE = 2'd1,
    CMD_FIND_FREE = 2'd2
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_NONE  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_READ,
    S_WRITE,
    S_SCAN,
    S_RESP
  } state_t;

  // Outcome of looking for the lowest free bit in one bitmap word.
  typedef struct packed {
    logic             hit;
    logic [POS_W-1:0] pos;
  } free_hit_t;

endpackage

/* design/pfba_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module pfba_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/pfba_word_scan.sv */
// Finds the lowest free bit of one bitmap word among the bits below a limit.
module pfba_word_scan #(
  parameter int WORD_BITS = 64,
  parameter int LIMIT_W   = 14
) (
  input  logic [WORD_BITS-1:0] word,
  input  logic [LIMIT_W-1:0]   limit,
  output pfba_pkg::free_hit_t  result
);

  always_comb begin
    result = '0;
    // Walk from the top so that the lowest qualifying bit wins.
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (!word[b] && (LIMIT_W'(b) < limit)) begin
        result.hit = 1'b1;
        result.pos = pfba_pkg::POS_W'(b);
      end
    end
  end

endmodule

/* design/page_frame_bitmap_allocator_unit.sv */
// Top level of the page frame bitmap allocator: sequencer, bitmap RAM and config port.
//
//  Channel   Direction  Handshake             Contents
//  in_*      request    tvalid/tready         command, page_index
//  out_*     result     tvalid/tready         status, found_page
//  cfg_*     config     APB psel/penable      page_count at byte address 0
//
// A mark in range passes decode, bitmap read, bit update and write back, and the result register
// load before its result is valid; a refused mark or an unused command goes from decode straight
// to the result load. A find scans one bitmap word per cycle between decode and result load, at
// most ceil(min(page_count, NUM_PAGES) / WORD_BITS) words and at least one, also for a zero count.
// After the synchronous active-low reset, the block clears every bitmap word with in_tready
// low (configuration writes are taken meanwhile). One request is in flight at a time; a
// result waiting for out_tready stalls only the result load of the next request.
module page_frame_bitmap_allocator_unit #(
  parameter int NUM_PAGES = 4096,
  parameter int WORD_BITS = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Request channel. in_tdata: [1:0] command, [13:2] page_index, [15:14] zero.
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [pfba_pkg::IN_DATA_W-1:0]    in_tdata,
  // Result channel. out_tdata: [1:0] status, [13:2] found_page, [15:14] zero.
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [pfba_pkg::OUT_DATA_W-1:0]   out_tdata,
  // Configuration port.
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [pfba_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [pfba_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [pfba_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                              cfg_pready
);

  localparam int NUM_WORDS = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int WIDX_W    = NUM_WORDS > 1 ? $clog2(NUM_WORDS) : 1;
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int PAGE_W    = pfba_pkg::PAGE_W;
  localparam int COUNT_W   = pfba_pkg::COUNT_W;
  localparam int BASE_W    = COUNT_W + 1;
  // Page-to-word split by reciprocal multiplication, exact for every 12-bit page.
  localparam int DIV_S     = PAGE_W + $clog2(WORD_BITS);
  localparam int DIV_M     = ((1 << DIV_S) + WORD_BITS - 1) / WORD_BITS;
  localparam int PROD_W    = PAGE_W + DIV_S + 1;

  // Control state.
  pfba_pkg::state_t state_r, state_nxt;
  logic [WIDX_W-1:0] clr_r, clr_nxt;
  logic [COUNT_W-1:0] page_count_r;
  logic out_valid_r, out_valid_nxt;

  // Request and working registers.
  pfba_pkg::cmd_t cmd_r, cmd_nxt;
  logic [PAGE_W-1:0] page_r, page_nxt;
  logic [PAGE_W-1:0] quot_r, quot_nxt;
  logic [BIT_W-1:0]  bit_r, bit_nxt;
  logic [WIDX_W-1:0] rd_word_r, rd_word_nxt;
  logic [BASE_W-1:0] base_r, base_nxt;
  pfba_pkg::status_t res_status_r, res_status_nxt;
  logic [PAGE_W-1:0] res_page_r, res_page_nxt;
  pfba_pkg::status_t out_status_r, out_status_nxt;
  logic [PAGE_W-1:0] out_page_r, out_page_nxt;

  // Bitmap RAM ports.
  logic                 mem_we;
  logic [WIDX_W-1:0]    mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic [WIDX_W-1:0]    mem_raddr;
  logic [WORD_BITS-1:0] mem_rdata;

  // Derived values.
  logic [COUNT_W-1:0]   eff_count;
  logic                 in_accept;
  logic                 out_load;
  logic                 cfg_write;
  logic                 page_out_of_range;
  logic [PROD_W-1:0]    quot_prod;
  logic [PAGE_W-1:0]    page_rem;
  logic [BASE_W-1:0]    scan_limit;
  logic                 scan_last;
  logic [WORD_BITS-1:0] bit_mask;
  pfba_pkg::free_hit_t  scan_hit;

  // The page count saturates at the number of frames that exist.
  assign eff_count = ((NUM_PAGES < (1 << COUNT_W)) && (page_count_r > COUNT_W'(NUM_PAGES)))
                     ? COUNT_W'(NUM_PAGES) : page_count_r;

  assign in_tready  = (state_r == pfba_pkg::S_IDLE);
  assign in_accept  = in_tvalid && in_tready;
  assign out_load   = (state_r == pfba_pkg::S_RESP) && (!out_valid_r || out_tready);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_page_r, out_status_r};

  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                      && (cfg_paddr == pfba_pkg::REG_PAGE_COUNT);
  assign cfg_prdata = (cfg_paddr == pfba_pkg::REG_PAGE_COUNT)
                      ? {{(pfba_pkg::CFG_DATA_W - COUNT_W){1'b0}}, page_count_r} : '0;

  assign page_out_of_range = ({1'b0, page_r} >= eff_count);
  assign quot_prod  = PROD_W'(page_r) * PROD_W'(DIV_M);
  assign page_rem   = page_r - PAGE_W'(quot_r * PAGE_W'(WORD_BITS));
  assign bit_mask   = WORD_BITS'(1) << bit_r;

  // During a scan, base_r is the first page of the word whose data arrives now.
  assign scan_limit = BASE_W'(eff_count) - base_r;
  assign scan_last  = (base_r + BASE_W'(WORD_BITS)) >= BASE_W'(eff_count);

  pfba_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (NUM_WORDS)
  ) u_bitmap (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  pfba_word_scan #(
    .WORD_BITS (WORD_BITS),
    .LIMIT_W   (BASE_W)
  ) u_scan (
    .word   (mem_rdata),
    .limit  (scan_limit),
    .result (scan_hit)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pfba_pkg::S_CLEAR: begin
        if (clr_r == WIDX_W'(NUM_WORDS - 1)) begin
          state_nxt = pfba_pkg::S_IDLE;
        end
      end
      pfba_pkg::S_IDLE: begin
        if (in_accept) begin
          state_nxt = pfba_pkg::S_DECODE;
        end
      end
      pfba_pkg::S_DECODE: begin
        unique case (cmd_r)
          pfba_pkg::CMD_MARK_USED,
          pfba_pkg::CMD_MARK_FREE: begin
            state_nxt = page_out_of_range ? pfba_pkg::S_RESP : pfba_pkg::S_READ;
          end
          pfba_pkg::CMD_FIND_FREE: state_nxt = pfba_pkg::S_SCAN;
          default:                 state_nxt = pfba_pkg::S_RESP;
        endcase
      end
      pfba_pkg::S_READ:  state_nxt = pfba_pkg::S_WRITE;
      pfba_pkg::S_WRITE: state_nxt = pfba_pkg::S_RESP;
      pfba_pkg::S_SCAN: begin
        if (scan_hit.hit || scan_last) begin
          state_nxt = pfba_pkg::S_RESP;
        end
      end
      pfba_pkg::S_RESP: begin
        if (out_load) begin
          state_nxt = pfba_pkg::S_IDLE;
        end
      end
      default: state_nxt = pfba_pkg::S_IDLE;
    endcase
  end

  // Datapath, RAM controls and result registers.
  always_comb begin
    clr_nxt        = clr_r;
    cmd_nxt        = cmd_r;
    page_nxt       = page_r;
    quot_nxt       = quot_r;
    bit_nxt        = bit_r;
    rd_word_nxt    = rd_word_r;
    base_nxt       = base_r;
    res_status_nxt = res_status_r;
    res_page_nxt   = res_page_r;
    out_status_nxt = out_status_r;
    out_page_nxt   = out_page_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    mem_we         = 1'b0;
    mem_waddr      = WIDX_W'(quot_r);
    mem_wdata      = '0;
    mem_raddr      = '0;

    unique case (state_r)
      pfba_pkg::S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = '0;
        clr_nxt   = clr_r + WIDX_W'(1);
      end
      pfba_pkg::S_IDLE: begin
        if (in_accept) begin
          cmd_nxt  = pfba_pkg::cmd_t'(in_tdata[1:0]);
          page_nxt = in_tdata[13:2];
        end
      end
      pfba_pkg::S_DECODE: begin
        quot_nxt     = PAGE_W'(quot_prod >> DIV_S);
        res_page_nxt = '0;
        rd_word_nxt  = '0;
        base_nxt     = '0;
        // Word 0 is fetched now so that a scan sees its data in the first scan cycle.
        mem_raddr    = '0;
        unique case (cmd_r)
          pfba_pkg::CMD_MARK_USED,
          pfba_pkg::CMD_MARK_FREE: begin
            res_status_nxt = page_out_of_range ? pfba_pkg::ST_RANGE : pfba_pkg::ST_OK;
          end
          pfba_pkg::CMD_FIND_FREE: res_status_nxt = pfba_pkg::ST_NONE;
          default:                 res_status_nxt = pfba_pkg::ST_OK;
        endcase
      end
      pfba_pkg::S_READ: begin
        mem_raddr = WIDX_W'(quot_r);
        bit_nxt   = BIT_W'(page_rem);
      end
      pfba_pkg::S_WRITE: begin
        mem_we    = 1'b1;
        mem_waddr = WIDX_W'(quot_r);
        mem_wdata = (cmd_r == pfba_pkg::CMD_MARK_USED) ? (mem_rdata | bit_mask)
                                                       : (mem_rdata & ~bit_mask);
      end
      pfba_pkg::S_SCAN: begin
        // The next word is fetched in every scan cycle, also after the last counted one.
        mem_raddr   = rd_word_r + WIDX_W'(1);
        rd_word_nxt = rd_word_r + WIDX_W'(1);
        base_nxt    = base_r + BASE_W'(WORD_BITS);
        if (scan_hit.hit) begin
          res_status_nxt = pfba_pkg::ST_OK;
          res_page_nxt   = PAGE_W'(base_r + BASE_W'(scan_hit.pos));
        end
      end
      pfba_pkg::S_RESP: begin
        if (out_load) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_page_nxt   = res_page_r;
        end
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= pfba_pkg::S_CLEAR;
      clr_r        <= '0;
      out_valid_r  <= 1'b0;
      page_count_r <= pfba_pkg::COUNT_RESET;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_write) begin
        page_count_r <= cfg_pwdata[COUNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    page_r       <= page_nxt;
    quot_r       <= quot_nxt;
    bit_r        <= bit_nxt;
    rd_word_r    <= rd_word_nxt;
    base_r       <= base_nxt;
    res_status_r <= res_status_nxt;
    res_page_r   <= res_page_nxt;
    out_status_r <= out_status_nxt;
    out_page_r   <= out_page_nxt;
  end

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the page frame bitmap allocator: directed table, random phases.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // The bitmap covers 4096 frames, so every 12-bit page number names a real frame.
  localparam int         FRAMES        = 4096;
  // Command code 3 is not decoded by the block; it must answer a plain ok.
  localparam logic [1:0] CMD_UNUSED    = 2'd3;
  // Cycles without any handshake before the run is declared hung. A find request
  // scans at most 64 words, and both the receiver stalls and the sender pauses
  // come in bounded bursts, so the limit is already generous.
  localparam int         HANG_LIMIT    = 1000;
  // Quiet time after the last result, enough for a stray extra result to show up.
  localparam int         DRAIN_CYCLES  = 100;

  typedef struct packed {
    pfba_pkg::status_t st;
    logic [11:0]       page;
  } page_result_t;

  // One row of the directed table: either a page_count write or a request,
  // optionally with an expectation typed in by hand.
  typedef struct {
    bit                is_cfg;
    logic [12:0]       cfg_value;
    logic [1:0]        cmd;
    logic [11:0]       page;
    bit                typed;
    pfba_pkg::status_t exp_st;
    logic [11:0]       exp_page;
  } script_row_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [pfba_pkg::IN_DATA_W-1:0]  in_tdata = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [pfba_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                            cfg_psel = 1'b0;
  logic                            cfg_penable = 1'b0;
  logic                            cfg_pwrite = 1'b0;
  logic [pfba_pkg::CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [pfba_pkg::CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [pfba_pkg::CFG_DATA_W-1:0] cfg_prdata;
  logic                            cfg_pready;

  // Shadow copy of the allocator state that the checker predicts from.
  logic [FRAMES-1:0]               frame_used;
  logic [pfba_pkg::COUNT_W-1:0]    frame_limit;

  // Results still owed by the block, oldest first.
  page_result_t          owed_results[$];
  int                    error_count = 0;
  int                    hang_cycles = 0;

  // Idling knobs, in percent. The receiver stalls in bursts of random length.
  int                    tx_pause_pct = 0;
  int                    rx_stall_pct = 0;
  int                    rx_stall_left = 0;

  page_frame_bitmap_allocator_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #4 clk = ~clk;

  // Frames that take part: the register value saturated to the bitmap size.
  function automatic int counted_frames();
    return (frame_limit > FRAMES) ? FRAMES : int'(frame_limit);
  endfunction

  // Lowest free frame below the count, or -1 when every counted frame is used.
  function automatic int lowest_free_frame();
    int lim;
    lim = counted_frames();
    for (int p = 0; p < lim; p++) begin
      if (!frame_used[p]) return p;
    end
    return -1;
  endfunction

  // Works out the answer to one accepted request and updates the shadow bitmap.
  function automatic page_result_t apply_page_request(input logic [1:0] cmd,
                                                      input logic [11:0] page);
    page_result_t r;
    int           hit;
    r.st   = pfba_pkg::ST_OK;
    r.page = '0;
    if (cmd == pfba_pkg::CMD_MARK_USED || cmd == pfba_pkg::CMD_MARK_FREE) begin
      // A mark outside the counted frames is refused and changes nothing.
      if (int'(page) >= counted_frames()) begin
        r.st = pfba_pkg::ST_RANGE;
      end else begin
        frame_used[page] = (cmd == pfba_pkg::CMD_MARK_USED);
      end
    end else if (cmd == pfba_pkg::CMD_FIND_FREE) begin
      // Find never marks anything; with nothing free it reports none.
      hit = lowest_free_frame();
      if (hit < 0) begin
        r.st = pfba_pkg::ST_NONE;
      end else begin
        r.page = hit[11:0];
      end
    end
    return r;
  endfunction

  // Pauses the request side for a random burst, now and then.
  task automatic maybe_pause_sender();
    if ($urandom_range(0, 99) < tx_pause_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  // Presents one request and waits until the block takes it. The valid stays
  // high afterwards so back-to-back requests need no extra cycle.
  task automatic send_request(input logic [1:0] cmd, input logic [11:0] page,
                              input bit typed, input pfba_pkg::status_t exp_st,
                              input logic [11:0] exp_page);
    page_result_t r;
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, page, cmd};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    r = apply_page_request(cmd, page);
    if (typed) begin
      r.st   = exp_st;
      r.page = exp_page;
    end
    owed_results.push_back(r);
    maybe_pause_sender();
  endtask

  // Writes page_count once every owed result is back, then reads it back.
  task automatic write_page_count(input logic [12:0] value);
    logic [31:0] junk;
    junk = $urandom;
    in_tvalid <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk);
    // Bits above the register width carry junk; the block must drop them.
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= pfba_pkg::REG_PAGE_COUNT;
    cfg_pwdata  <= {junk[31:13], value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    frame_limit = value;
    cfg_pwrite  <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (cfg_prdata[12:0] !== value) begin
      $display("%0t: page_count readback expected %0d got %0d", $time, value,
               cfg_prdata[12:0]);
      error_count++;
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // Receiver: random stall bursts whose frequency the stimulus sets per phase.
  always @(posedge clk) begin
    if (rx_stall_left > 0) begin
      rx_stall_left <= rx_stall_left - 1;
      out_tready    <= 1'b0;
    end else if ($urandom_range(0, 99) < rx_stall_pct) begin
      rx_stall_left <= $urandom_range(1, 17) - 1;
      out_tready    <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Result checker: every accepted result is matched against the oldest one owed.
  always @(posedge clk) begin
    page_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (owed_results.size() == 0) begin
        $display("%0t: result with none owed, got status %0d page %0d", $time,
                 out_tdata[1:0], out_tdata[13:2]);
        error_count++;
      end else begin
        want = owed_results.pop_front();
        if (out_tdata[1:0] !== want.st) begin
          $display("%0t: status expected %0d got %0d", $time, want.st, out_tdata[1:0]);
          error_count++;
        end
        if (out_tdata[13:2] !== want.page) begin
          $display("%0t: found_page expected %0d got %0d", $time, want.page,
                   out_tdata[13:2]);
          error_count++;
        end
      end
    end
  end

  // Watchdog: any handshake on any port counts as progress.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable && cfg_pready)) begin
      hang_cycles <= 0;
    end else if (hang_cycles >= HANG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, HANG_LIMIT);
      $display("TB_ERROR");
      $finish;
    end else begin
      hang_cycles <= hang_cycles + 1;
    end
  end

  initial begin
    script_row_t script[$];
    script_row_t row;
    int          phase_counts[10];
    int          sent;
    int          cnt;
    int          pick;
    int          lo;

    frame_used  = '0;
    frame_limit = pfba_pkg::COUNT_RESET;

    // Directed table. Expectations that follow plainly from the reset state,
    // the extremes or a refusal are written in; the others come from the predictor.
    // A find on a fresh bitmap hands out frame 0, whatever page_index says.
    script.push_back('{1'b0, 13'd0, pfba_pkg::CMD_FIND_FREE, 12'd0,
                       1'b1, pfba_pkg::ST_OK, 12'd0});
    script.push_back('{1'b0, 13'd0, pfba_pkg::CMD_MARK_USED, 12'd0,
                       1'b1, pfba_pkg::ST_OK, 12'd0});
    script.push_back('{1'b0, 13'd0, pfba_pkg::CMD_FIND_FREE, 12'd4095,
                       1'b1, pfba_pkg::ST_OK, 12'd1});
    script.push_back('{1'b0, 13'd0, pfba_pkg::CMD_MARK_USED, 12'd4095,
                       1'b1, pfba_pkg::ST_OK, 12'd0});
    script.push_back('{1'b0, 13'd0, pfba_pkg::CMD_MARK_FREE, 12'd4095,
                       1'b1, pfba_pkg::ST_OK, 12'd0});
    // The unused command code changes nothing and answers a plain ok.
    script.push_back('{1'b0, 13'd0, CMD_UNUSED, 12'd4095,
                       1'b1, pfba_pkg::ST_OK, 12'd0});
    script.push_back('{1'b0, 13'd0, pfba_pkg::CMD_MARK_FREE, 12'd0,
                       1'b1, pfba_pkg::ST_OK, 12'd0});
    script.push_back('{1'b0, 13'd0, pfba_pkg::CMD_MARK_USED, 12'd1,
                       1'b1, pfba_pkg::ST_OK, 12'd0});
    script.push_back('{1'b0, 13'd0, pfba_pkg::CMD_FIND_FREE, 12'd2730,
                       1'b1, pfba_pkg::ST_OK, 12'd0});
    // With a count of zero every mark is refused and find reports nothing free.
    script.push_back('{1'b1, 13'd0, 2'd0, 12'd0,
                       1'b0, pfba_pkg::ST_OK, 12'd0});
    script.push_back('{1'b0, 13'd0, pfba_pkg::CMD_MARK_USED, 12'd0,
                       1'b1, pfba_pkg::ST_RANGE, 12'd0});
    script.push_back('{1'b0, 13'd0, pfba_pkg::CMD_MARK_FREE, 12'd4095,
                       1'b1, pfba_pkg::ST_RANGE, 12'd0});
    script.push_back('{1'b0, 13'd0, pfba_pkg::CMD_FIND_FREE, 12'd0,
                       1'b1, pfba_pkg::ST_NONE, 12'd0});
    // A single counted frame: once it is used nothing is free.
    script.push_back('{1'b1, 13'd1, 2'd0, 12'd0,
                       1'b0, pfba_pkg::ST_OK, 12'd0});
    script.push_back('{1'b0, 13'd0, pfba_pkg::CMD_MARK_USED, 12'd0,
                       1'b1, pfba_pkg::ST_OK, 12'd0});
    script.push_back('{1'b0, 13'd0, pfba_pkg::CMD_FIND_FREE, 12'd1365,
                       1'b1, pfba_pkg::ST_NONE, 12'd0});
    script.push_back('{1'b0, 13'd0, pfba_pkg::CMD_MARK_USED, 12'd1,
                       1'b1, pfba_pkg::ST_RANGE, 12'd0});
    // The largest register value saturates to the full bitmap.
    script.push_back('{1'b1, 13'd8191, 2'd0, 12'd0,
                       1'b0, pfba_pkg::ST_OK, 12'd0});
    script.push_back('{1'b0, 13'd0, pfba_pkg::CMD_MARK_USED, 12'd4095,
                       1'b1, pfba_pkg::ST_OK, 12'd0});
    script.push_back('{1'b0, 13'd0, pfba_pkg::CMD_FIND_FREE, 12'd0,
                       1'b0, pfba_pkg::ST_OK, 12'd0});
    // A count that ends one word into the bitmap leaves a partial trailing word.
    script.push_back('{1'b1, 13'd65, 2'd0, 12'd0,
                       1'b0, pfba_pkg::ST_OK, 12'd0});
    script.push_back('{1'b0, 13'd0, pfba_pkg::CMD_MARK_USED, 12'd64,
                       1'b0, pfba_pkg::ST_OK, 12'd0});
    script.push_back('{1'b0, 13'd0, pfba_pkg::CMD_MARK_USED, 12'd65,
                       1'b1, pfba_pkg::ST_RANGE, 12'd0});
    script.push_back('{1'b0, 13'd0, CMD_UNUSED, 12'd0,
                       1'b1, pfba_pkg::ST_OK, 12'd0});

    // Reset is held first; the block then clears its bitmap on its own
    // while in_tready stays low, which the request handshake simply waits out.
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    tx_pause_pct = 20;
    rx_stall_pct = 15;

    foreach (script[i]) begin
      row = script[i];
      if (row.is_cfg) begin
        write_page_count(row.cfg_value);
      end else begin
        send_request(row.cmd, row.page, row.typed, row.exp_st, row.exp_page);
      end
    end

    // Random phases. Each one sets a page count and then mostly allocates: a find
    // request followed by a mark of the frame it returned, so the low frames fill
    // up over the run and later finds have to skip whole used words. Frees,
    // refused marks, boundary pages and the unused command are mixed in. The
    // bitmap carries over from phase to phase.
    phase_counts = '{65, 64, 63, 130, 0, 1, 8191, 200, 4095, 4096};
    phase_counts[7] = $urandom_range(2, 300);
    for (int ph = 0; ph < 10; ph++) begin
      // The last two phases run without any idling; one early phase too.
      if (ph >= 8 || ph == 3) begin
        tx_pause_pct = 0;
        rx_stall_pct = 0;
      end else begin
        tx_pause_pct = (ph % 2 == 0) ? 25 : 10;
        rx_stall_pct = (ph % 2 == 0) ? 10 : 25;
      end
      write_page_count(phase_counts[ph][12:0]);
      cnt  = counted_frames();
      sent = 0;
      while (sent < 45) begin
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
          send_request(pfba_pkg::CMD_FIND_FREE, 12'($urandom), 1'b0, pfba_pkg::ST_OK,
                       12'd0);
          sent++;
          lo = lowest_free_frame();
          if (lo >= 0) begin
            send_request(pfba_pkg::CMD_MARK_USED, lo[11:0], 1'b0, pfba_pkg::ST_OK, 12'd0);
            sent++;
          end
        end else if (pick < 55) begin
          lo = (cnt > 0) ? $urandom_range(0, cnt - 1) : $urandom_range(0, FRAMES - 1);
          send_request(pfba_pkg::CMD_MARK_FREE, lo[11:0], 1'b0, pfba_pkg::ST_OK, 12'd0);
          sent++;
        end else if (pick < 65) begin
          send_request(pfba_pkg::CMD_FIND_FREE, 12'($urandom), 1'b0, pfba_pkg::ST_OK,
                       12'd0);
          sent++;
        end else if (pick < 80) begin
          send_request({1'b0, 1'($urandom)}, 12'($urandom), 1'b0, pfba_pkg::ST_OK, 12'd0);
          sent++;
        end else if (pick < 88) begin
          // Just inside or just outside the counted frames.
          lo = $urandom_range(0, 1) ? cnt : cnt - 1;
          if (lo < 0) lo = 0;
          if (lo > FRAMES - 1) lo = FRAMES - 1;
          send_request({1'b0, 1'($urandom)}, lo[11:0], 1'b0, pfba_pkg::ST_OK, 12'd0);
          sent++;
        end else if (pick < 94) begin
          send_request(CMD_UNUSED, 12'($urandom), 1'b0, pfba_pkg::ST_OK, 12'd0);
          sent++;
        end else begin
          lo = (cnt > 0) ? $urandom_range(0, cnt - 1) : $urandom_range(0, FRAMES - 1);
          send_request(pfba_pkg::CMD_MARK_USED, lo[11:0], 1'b0, pfba_pkg::ST_OK, 12'd0);
          sent++;
        end
      end
    end

    // Drain: wait for every owed result, then watch for anything extra.
    in_tvalid <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
